// ----- rtl/rvd_pkg.sv -----
// Shared opcode values, instruction kind codes and the decoded result type.
package rvd_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned KIND_W = 6;

	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;

	typedef enum logic [KIND_W-1:0] {
		K_INVALID = 6'd0,
		K_LUI     = 6'd1,
		K_AUIPC   = 6'd2,
		K_JAL     = 6'd3,
		K_JALR    = 6'd4,
		K_BEQ     = 6'd5,
		K_BNE     = 6'd6,
		K_BLT     = 6'd7,
		K_BGE     = 6'd8,
		K_BLTU    = 6'd9,
		K_BGEU    = 6'd10,
		K_LB      = 6'd11,
		K_LH      = 6'd12,
		K_LW      = 6'd13,
		K_LBU     = 6'd14,
		K_LHU     = 6'd15,
		K_SB      = 6'd16,
		K_SH      = 6'd17,
		K_SW      = 6'd18,
		K_ADDI    = 6'd19,
		K_SLTI    = 6'd20,
		K_SLTIU   = 6'd21,
		K_XORI    = 6'd22,
		K_ORI     = 6'd23,
		K_ANDI    = 6'd24,
		K_SLLI    = 6'd25,
		K_SRLI    = 6'd26,
		K_SRAI    = 6'd27,
		K_ADD     = 6'd28,
		K_SUB     = 6'd29,
		K_SLL     = 6'd30,
		K_SLT     = 6'd31,
		K_SLTU    = 6'd32,
		K_XOR     = 6'd33,
		K_SRL     = 6'd34,
		K_SRA     = 6'd35,
		K_OR      = 6'd36,
		K_AND     = 6'd37
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [6:0]         major_opcode;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic [4:0]         shift_amount;
		logic signed [31:0] immediate;
	} decoded_t;

endpackage

// ----- rtl/rvd_decode.sv -----
// Combinational decode of one RV32I instruction word into kind, fields and immediate.
module rvd_decode (
	input  logic [rvd_pkg::WORD_W-1:0] word,
	output rvd_pkg::decoded_t          dec
);

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic        b30;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_u;
	logic [31:0] imm_j;
	rvd_pkg::kind_t kind;
	logic [31:0] imm;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign b30 = word[30];

	assign imm_i = {{21{word[31]}}, word[30:20]};
	assign imm_s = {{21{word[31]}}, word[30:25], word[11:7]};
	assign imm_b = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
	assign imm_u = {word[31:12], 12'h000};
	assign imm_j = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};

	always_comb begin
		kind = rvd_pkg::K_INVALID;
		imm  = '0;
		case (opc)
			rvd_pkg::OPC_LUI: begin
				kind = rvd_pkg::K_LUI;
				imm  = imm_u;
			end
			rvd_pkg::OPC_AUIPC: begin
				kind = rvd_pkg::K_AUIPC;
				imm  = imm_u;
			end
			rvd_pkg::OPC_JAL: begin
				kind = rvd_pkg::K_JAL;
				imm  = imm_j;
			end
			rvd_pkg::OPC_JALR: begin
				kind = rvd_pkg::K_JALR;
				imm  = imm_i;
			end
			rvd_pkg::OPC_BRANCH: begin
				imm = imm_b;
				case (f3)
					3'd0: kind = rvd_pkg::K_BEQ;
					3'd1: kind = rvd_pkg::K_BNE;
					3'd4: kind = rvd_pkg::K_BLT;
					3'd5: kind = rvd_pkg::K_BGE;
					3'd6: kind = rvd_pkg::K_BLTU;
					3'd7: kind = rvd_pkg::K_BGEU;
					default: kind = rvd_pkg::K_INVALID;
				endcase
			end
			rvd_pkg::OPC_LOAD: begin
				imm = imm_i;
				case (f3)
					3'd0: kind = rvd_pkg::K_LB;
					3'd1: kind = rvd_pkg::K_LH;
					3'd2: kind = rvd_pkg::K_LW;
					3'd4: kind = rvd_pkg::K_LBU;
					3'd5: kind = rvd_pkg::K_LHU;
					default: kind = rvd_pkg::K_INVALID;
				endcase
			end
			rvd_pkg::OPC_STORE: begin
				imm = imm_s;
				case (f3)
					3'd0: kind = rvd_pkg::K_SB;
					3'd1: kind = rvd_pkg::K_SH;
					3'd2: kind = rvd_pkg::K_SW;
					default: kind = rvd_pkg::K_INVALID;
				endcase
			end
			rvd_pkg::OPC_OPIMM: begin
				imm = imm_i;
				case (f3)
					3'd0: kind = rvd_pkg::K_ADDI;
					3'd1: kind = rvd_pkg::K_SLLI;
					3'd2: kind = rvd_pkg::K_SLTI;
					3'd3: kind = rvd_pkg::K_SLTIU;
					3'd4: kind = rvd_pkg::K_XORI;
					3'd5: kind = b30 ? rvd_pkg::K_SRAI : rvd_pkg::K_SRLI;
					3'd6: kind = rvd_pkg::K_ORI;
					3'd7: kind = rvd_pkg::K_ANDI;
					default: kind = rvd_pkg::K_INVALID;
				endcase
			end
			rvd_pkg::OPC_OP: begin
				imm = '0;
				case (f3)
					3'd0: kind = b30 ? rvd_pkg::K_SUB : rvd_pkg::K_ADD;
					3'd1: kind = rvd_pkg::K_SLL;
					3'd2: kind = rvd_pkg::K_SLT;
					3'd3: kind = rvd_pkg::K_SLTU;
					3'd4: kind = rvd_pkg::K_XOR;
					3'd5: kind = b30 ? rvd_pkg::K_SRA : rvd_pkg::K_SRL;
					3'd6: kind = rvd_pkg::K_OR;
					3'd7: kind = rvd_pkg::K_AND;
					default: kind = rvd_pkg::K_INVALID;
				endcase
			end
			default: begin
				kind = rvd_pkg::K_INVALID;
				imm  = '0;
			end
		endcase
	end

	always_comb begin
		dec.kind         = kind;
		dec.major_opcode = opc;
		dec.dest_reg     = word[11:7];
		dec.src1_reg     = word[19:15];
		dec.src2_reg     = word[24:20];
		dec.shift_amount = word[24:20];
		dec.immediate    = $signed(imm);
	end

endmodule

// ----- rtl/rv32i_instruction_decoder.sv -----
// Top level of the RV32I instruction decoder: input register, decode, result register.
//
// Input channel: in_valid / in_ready carry instruction_word. Output channel:
// out_valid / out_ready carry kind, major_opcode, dest_reg, src1_reg, src2_reg,
// shift_amount and immediate. A transaction happens when valid and ready are
// both high at a rising edge of clk.
// An accepted word is held in the input register, decoded by combinational
// logic, and captured in the result register when that register can load;
// the result is then offered on the output channel until it is taken.
// Throughput is one instruction per cycle while out_ready stays high; the decode
// between the two registers is an opcode, funct3 and bit 30 lookup plus immediate assembly.
// When the receiver holds out_ready low, the result register keeps its
// transaction and the input register still takes one more word; in_ready
// then drops until the result is taken. in_ready depends combinationally on
// out_ready through the two stage enables.
// Asynchronous reset (arst_n low) empties both registers; no result is
// offered until a new word is accepted. There is no configuration.
module rv32i_instruction_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rvd_pkg::WORD_W-1:0]        instruction_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rvd_pkg::KIND_W-1:0]        kind,
	output logic [6:0]                        major_opcode,
	output logic [4:0]                        dest_reg,
	output logic [4:0]                        src1_reg,
	output logic [4:0]                        src2_reg,
	output logic [4:0]                        shift_amount,
	output logic signed [31:0]                immediate
);

	logic                       valid_s1;
	logic [rvd_pkg::WORD_W-1:0] word_s1;
	logic                       valid_s2;
	rvd_pkg::decoded_t          dec_s2;
	rvd_pkg::decoded_t          dec;
	logic                       adv_s2;
	logic                       adv_s1;

	// The result register can load when it is empty or being drained.
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= instruction_word;
		end
	end

	rvd_decode u_decode (
		.word (word_s1),
		.dec  (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			dec_s2 <= dec;
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = dec_s2.kind;
	assign major_opcode = dec_s2.major_opcode;
	assign dest_reg     = dec_s2.dest_reg;
	assign src1_reg     = dec_s2.src1_reg;
	assign src2_reg     = dec_s2.src2_reg;
	assign shift_amount = dec_s2.shift_amount;
	assign immediate    = dec_s2.immediate;

	// A word in the input register moves to the result register when it can.
	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("decoded word was not moved to the result register");

	// A valid kind only comes from one of the known major opcodes.
	a_kind_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != rvd_pkg::K_INVALID |->
			major_opcode == rvd_pkg::OPC_LUI || major_opcode == rvd_pkg::OPC_AUIPC ||
			major_opcode == rvd_pkg::OPC_JAL || major_opcode == rvd_pkg::OPC_JALR ||
			major_opcode == rvd_pkg::OPC_BRANCH || major_opcode == rvd_pkg::OPC_LOAD ||
			major_opcode == rvd_pkg::OPC_STORE || major_opcode == rvd_pkg::OPC_OPIMM ||
			major_opcode == rvd_pkg::OPC_OP)
		else $error("valid kind decoded from an unknown opcode");

	// Register-register operations carry no immediate.
	a_op_imm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && major_opcode == rvd_pkg::OPC_OP |-> immediate == 32'sd0)
		else $error("register-register operation has a nonzero immediate");

	// The shift amount and second source always come from the same bits.
	a_shamt_src2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> shift_amount == src2_reg)
		else $error("shift amount differs from second source field");

	// Kind codes stay within the defined range.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= rvd_pkg::K_AND)
		else $error("kind code out of range");

endmodule

// ----- tb/sv/tb_rv32i_instruction_decoder.sv -----
// Self-checking testbench for the RV32I decoder: random words, stalls and a decode predictor.
module tb_rv32i_instruction_decoder;

	localparam int RANDOM_ITEMS = 2000;
	localparam int CALM_TAIL    = 200;

	typedef struct {
		logic [31:0] word;
		bit          hold;
	} fetch_item_t;

	typedef struct {
		logic [31:0]       word;
		rvd_pkg::decoded_t dec;
	} decode_expect_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [31:0]                instruction_word = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [rvd_pkg::KIND_W-1:0] kind;
	logic [6:0]                 major_opcode;
	logic [4:0]                 dest_reg;
	logic [4:0]                 src1_reg;
	logic [4:0]                 src2_reg;
	logic [4:0]                 shift_amount;
	logic signed [31:0]         immediate;

	fetch_item_t    fetch_q[$];
	decode_expect_t decode_expect_q[$];

	int          error_count = 0;
	int          directed_count = 0;
	int          accepted_count = 0;
	int          checked_count = 0;
	bit [37:0]   kinds_seen = '0;
	logic        drained = 1'b1;
	logic        calm = 1'b0;

	rv32i_instruction_decoder i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.instruction_word (instruction_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.major_opcode     (major_opcode),
		.dest_reg         (dest_reg),
		.src1_reg         (src1_reg),
		.src2_reg         (src2_reg),
		.shift_amount     (shift_amount),
		.immediate        (immediate)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("tb_rv32i_instruction_decoder: FAIL");
		$finish;
	end

	function automatic rvd_pkg::decoded_t decode_rv32i(input logic [31:0] w);
		rvd_pkg::decoded_t d;
		logic [31:0] imm_i;
		logic [31:0] imm_s;
		logic [31:0] imm_b;
		logic [31:0] imm_u;
		logic [31:0] imm_j;
		imm_i = {{21{w[31]}}, w[30:20]};
		imm_s = {{21{w[31]}}, w[30:25], w[11:7]};
		imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
		imm_u = {w[31:12], 12'b0};
		imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
		d.kind         = rvd_pkg::K_INVALID;
		d.immediate    = '0;
		d.major_opcode = w[6:0];
		d.dest_reg     = w[11:7];
		d.src1_reg     = w[19:15];
		d.src2_reg     = w[24:20];
		d.shift_amount = w[24:20];
		case (w[6:0])
			rvd_pkg::OPC_LUI: begin
				d.kind = rvd_pkg::K_LUI;
				d.immediate = imm_u;
			end
			rvd_pkg::OPC_AUIPC: begin
				d.kind = rvd_pkg::K_AUIPC;
				d.immediate = imm_u;
			end
			rvd_pkg::OPC_JAL: begin
				d.kind = rvd_pkg::K_JAL;
				d.immediate = imm_j;
			end
			rvd_pkg::OPC_JALR: begin
				d.kind = rvd_pkg::K_JALR;
				d.immediate = imm_i;
			end
			rvd_pkg::OPC_BRANCH: begin
				d.immediate = imm_b;
				case (w[14:12])
					3'd0: d.kind = rvd_pkg::K_BEQ;
					3'd1: d.kind = rvd_pkg::K_BNE;
					3'd4: d.kind = rvd_pkg::K_BLT;
					3'd5: d.kind = rvd_pkg::K_BGE;
					3'd6: d.kind = rvd_pkg::K_BLTU;
					3'd7: d.kind = rvd_pkg::K_BGEU;
					default: d.kind = rvd_pkg::K_INVALID;
				endcase
			end
			rvd_pkg::OPC_LOAD: begin
				d.immediate = imm_i;
				case (w[14:12])
					3'd0: d.kind = rvd_pkg::K_LB;
					3'd1: d.kind = rvd_pkg::K_LH;
					3'd2: d.kind = rvd_pkg::K_LW;
					3'd4: d.kind = rvd_pkg::K_LBU;
					3'd5: d.kind = rvd_pkg::K_LHU;
					default: d.kind = rvd_pkg::K_INVALID;
				endcase
			end
			rvd_pkg::OPC_STORE: begin
				d.immediate = imm_s;
				case (w[14:12])
					3'd0: d.kind = rvd_pkg::K_SB;
					3'd1: d.kind = rvd_pkg::K_SH;
					3'd2: d.kind = rvd_pkg::K_SW;
					default: d.kind = rvd_pkg::K_INVALID;
				endcase
			end
			rvd_pkg::OPC_OPIMM: begin
				d.immediate = imm_i;
				case (w[14:12])
					3'd0: d.kind = rvd_pkg::K_ADDI;
					3'd1: d.kind = rvd_pkg::K_SLLI;
					3'd2: d.kind = rvd_pkg::K_SLTI;
					3'd3: d.kind = rvd_pkg::K_SLTIU;
					3'd4: d.kind = rvd_pkg::K_XORI;
					3'd5: d.kind = w[30] ? rvd_pkg::K_SRAI : rvd_pkg::K_SRLI;
					3'd6: d.kind = rvd_pkg::K_ORI;
					default: d.kind = rvd_pkg::K_ANDI;
				endcase
			end
			rvd_pkg::OPC_OP: begin
				case (w[14:12])
					3'd0: d.kind = w[30] ? rvd_pkg::K_SUB : rvd_pkg::K_ADD;
					3'd1: d.kind = rvd_pkg::K_SLL;
					3'd2: d.kind = rvd_pkg::K_SLT;
					3'd3: d.kind = rvd_pkg::K_SLTU;
					3'd4: d.kind = rvd_pkg::K_XOR;
					3'd5: d.kind = w[30] ? rvd_pkg::K_SRA : rvd_pkg::K_SRL;
					3'd6: d.kind = rvd_pkg::K_OR;
					default: d.kind = rvd_pkg::K_AND;
				endcase
			end
			default: begin
				d.kind = rvd_pkg::K_INVALID;
			end
		endcase
		return d;
	endfunction

	function automatic logic [31:0] encode_word(input logic [6:0] opc, input logic [2:0] f3,
			input logic b30, input logic [31:0] fill);
		return {fill[31], b30, fill[29:15], f3, fill[11:7], opc};
	endfunction

	function automatic logic [6:0] group_opcode(input int unsigned idx);
		case (idx)
			0: return rvd_pkg::OPC_LUI;
			1: return rvd_pkg::OPC_AUIPC;
			2: return rvd_pkg::OPC_JAL;
			3: return rvd_pkg::OPC_JALR;
			4: return rvd_pkg::OPC_BRANCH;
			5: return rvd_pkg::OPC_LOAD;
			6: return rvd_pkg::OPC_STORE;
			7: return rvd_pkg::OPC_OPIMM;
			default: return rvd_pkg::OPC_OP;
		endcase
	endfunction

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(3))
			0: return 0;
			1: return 8;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	task automatic add_word(input logic [31:0] w, input bit hold);
		fetch_item_t it;
		it.word = w;
		it.hold = hold;
		fetch_q.push_back(it);
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] word,
			input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %h %s: got %h, expected %h", word, name, got, want));
	endtask

	// Driver: presents queued words, inserts idle bursts, and holds back a word
	// marked for a pause until the decoder has delivered every pending result.
	int unsigned idle_left = 0;
	int unsigned idle_pct = 0;
	int unsigned sent_n = 0;
	fetch_item_t next_item;
	logic        send;

	always @(posedge clk) begin
		if (arst_n) begin
			if (!(in_valid && !in_ready)) begin
				send = 1'b0;
				if (idle_left != 0) begin
					idle_left--;
				end else if (fetch_q.size() != 0) begin
					if (fetch_q[0].hold && !(drained && !in_valid)) begin
						send = 1'b0;
					end else if (!calm && $urandom_range(99) < idle_pct) begin
						idle_left = $urandom_range(13, 0);
					end else begin
						send = 1'b1;
						next_item = fetch_q.pop_front();
						sent_n++;
						if (sent_n % 150 == 0)
							idle_pct = pick_idle_pct();
					end
				end
				in_valid <= send;
				instruction_word <= send ? next_item.word : $urandom;
			end
			calm <= (fetch_q.size() < CALM_TAIL);
		end
	end

	// Monitor: checks each output transaction against the oldest prediction,
	// then records a prediction for any word accepted at this edge, and drives out_ready with random stalls.
	int unsigned stall_left = 0;
	int unsigned stall_pct = 0;
	int unsigned mon_cycles = 0;
	decode_expect_t got_exp;
	decode_expect_t new_exp;
	logic           take;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (decode_expect_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected, kind %0d", kind));
				end else begin
					got_exp = decode_expect_q.pop_front();
					check_field("kind", got_exp.word, 32'(kind), 32'(got_exp.dec.kind));
					check_field("major_opcode", got_exp.word, 32'(major_opcode),
						32'(got_exp.dec.major_opcode));
					check_field("dest_reg", got_exp.word, 32'(dest_reg),
						32'(got_exp.dec.dest_reg));
					check_field("src1_reg", got_exp.word, 32'(src1_reg),
						32'(got_exp.dec.src1_reg));
					check_field("src2_reg", got_exp.word, 32'(src2_reg),
						32'(got_exp.dec.src2_reg));
					check_field("shift_amount", got_exp.word, 32'(shift_amount),
						32'(got_exp.dec.shift_amount));
					check_field("immediate", got_exp.word, immediate, got_exp.dec.immediate);
					kinds_seen[got_exp.dec.kind] = 1'b1;
					checked_count++;
				end
			end
			if (in_valid && in_ready) begin
				new_exp.word = instruction_word;
				new_exp.dec = decode_rv32i(instruction_word);
				decode_expect_q.push_back(new_exp);
				accepted_count++;
			end
			drained <= (decode_expect_q.size() == 0);

			mon_cycles++;
			if (mon_cycles % 256 == 0)
				stall_pct = pick_idle_pct();
			take = 1'b1;
			if (stall_left != 0) begin
				stall_left--;
				take = 1'b0;
			end else if (!calm && $urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(13, 0);
				take = 1'b0;
			end
			out_ready <= take;
		end
	end

	initial begin
		logic [31:0] fill;
		logic [31:0] w;
		bit          hold;
		fill = '0;

		// Every operation once, with the remaining bits alternating between all
		// zeros and all ones so that register fields and immediates hit both ends.
		add_word(32'h0000_0000, 1'b0);
		add_word(32'hffff_ffff, 1'b0);
		add_word(encode_word(rvd_pkg::OPC_LUI, fill[14:12], fill[30], fill), 1'b0);
		fill = ~fill;
		add_word(encode_word(rvd_pkg::OPC_AUIPC, fill[14:12], fill[30], fill), 1'b0);
		fill = ~fill;
		add_word(encode_word(rvd_pkg::OPC_JAL, fill[14:12], fill[30], fill), 1'b0);
		fill = ~fill;
		add_word(encode_word(rvd_pkg::OPC_JALR, fill[14:12], fill[30], fill), 1'b0);
		// Branch and load/store groups include undefined funct3 values, which
		// still carry the group's immediate.
		for (int f = 0; f < 8; f++) begin
			fill = ~fill;
			add_word(encode_word(rvd_pkg::OPC_BRANCH, f[2:0], fill[30], fill), 1'b0);
		end
		for (int f = 0; f < 6; f++) begin
			fill = ~fill;
			add_word(encode_word(rvd_pkg::OPC_LOAD, f[2:0], fill[30], fill), 1'b0);
		end
		for (int f = 0; f < 4; f++) begin
			fill = ~fill;
			add_word(encode_word(rvd_pkg::OPC_STORE, f[2:0], fill[30], fill), 1'b0);
		end
		for (int f = 0; f < 8; f++) begin
			fill = ~fill;
			add_word(encode_word(rvd_pkg::OPC_OPIMM, f[2:0], (f == 5) ? 1'b0 : fill[30],
				fill), 1'b0);
		end
		add_word(encode_word(rvd_pkg::OPC_OPIMM, 3'd5, 1'b1, fill), 1'b0);
		// Bit 30 set on funct3 values where it must be ignored.
		for (int f = 0; f < 8; f++) begin
			fill = ~fill;
			add_word(encode_word(rvd_pkg::OPC_OP, f[2:0],
				(f == 0 || f == 5) ? 1'b0 : 1'b1, fill), 1'b0);
		end
		add_word(encode_word(rvd_pkg::OPC_OP, 3'd0, 1'b1, fill), 1'b0);
		add_word(encode_word(rvd_pkg::OPC_OP, 3'd5, 1'b1, ~fill), 1'b0);
		directed_count = fetch_q.size();

		// Mostly well-formed words from the nine groups with random content; the
		// rest are raw random words, which nearly always carry unknown opcodes.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			hold = (i == 0) || (i == RANDOM_ITEMS / 3) ||
				((i < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(399) == 0));
			if ($urandom_range(9) < 8)
				w = encode_word(group_opcode($urandom_range(8)), 3'($urandom),
					1'($urandom), $urandom);
			else
				w = $urandom;
			add_word(w, hold);
		end

		@(posedge arst_n);
		while (fetch_q.size() != 0 || in_valid || decode_expect_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		$display("Decoded %0d instruction words (%0d directed, rest random) under random stalls.",
			accepted_count, directed_count);
		$display("Checked %0d results covering %0d of 38 kind codes including invalid.",
			checked_count, $countones(kinds_seen));
		if (error_count == 0)
			$display("tb_rv32i_instruction_decoder: PASS");
		else
			$display("tb_rv32i_instruction_decoder: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rvd_pkg.sv
rtl/rvd_decode.sv
rtl/rv32i_instruction_decoder.sv
tb/sv/tb_rv32i_instruction_decoder.sv
